FILE: hdl/pac_pkg.sv
// ---------------------------------------------------------------------------
// pac_pkg: shared constants for the polygon area and centroid block
// field widths, accumulator widths and the default fraction width
// ---------------------------------------------------------------------------
package pac_pkg;

  // vertex coordinate width, signed
  localparam int COORD_BITS    = 16;
  // default number of fraction bits of the centroid
  localparam int FRAC_BITS_DEF = 8;

  // edge sum (x0 + x1) and cross product widths
  localparam int SUM_W  = COORD_BITS + 1;
  localparam int CP_W   = 2 * COORD_BITS + 1;
  localparam int PROD_W = CP_W + SUM_W;

  // accumulator and result widths
  localparam int CROSS_W = 44;
  localparam int MOM_W   = 61;
  localparam int AREA_W  = 44;
  localparam int CENT_W  = 24;

endpackage

FILE: hdl/polygon_area_centroid.sv
// ---------------------------------------------------------------------------
// polygon_area_centroid: shoelace area and centroid of a vertex stream
// each edge adds its cross product and moments through one shared multiplier;
// the final vertex closes the polygon and a shift-subtract divider gives the
// centroid as signed fixed point, rounded half away from zero and saturated
// ---------------------------------------------------------------------------
// sequencing: the first vertex of a polygon is taken while idle; each further
//   vertex holds the input while its edge runs through states S_M1 to S_M6,
//   so no new vertex is taken before that edge is done; the final vertex adds
//   the closing edge, then area set-up and, for a nonzero area, the divider for
//   x then y; the result beat then waits in S_PUB for the output register
// throughput is set by the single multiplier, the bit-serial divider and result back-pressure
// reset: sequencer, polygon flag and result valid cleared; no clearing pass
module polygon_area_centroid #(
  parameter int FRAC_BITS = pac_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // vertex channel
  input  logic                                 vertex_valid,
  output logic                                 vertex_stall,
  input  logic signed [pac_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pac_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                 last_vertex,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic        [pac_pkg::AREA_W-1:0]    twice_area,
  output logic signed [pac_pkg::CENT_W-1:0]    centroid_x,
  output logic signed [pac_pkg::CENT_W-1:0]    centroid_y,
  output logic                                 degenerate
);

  import pac_pkg::*;

  // divider widths: dividend is |m| * 2^(F+1) + 3|s|, divisor is 6|s|
  localparam int D1_W  = CROSS_W + 1;
  localparam int D_W   = CROSS_W + 2;
  localparam int NUM_W = MOM_W + FRAC_BITS + 2;
  localparam int HI_W  = NUM_W - CENT_W;
  localparam int CMP_W = (HI_W > D_W) ? HI_W : D_W;
  localparam int CNT_W = $clog2(CENT_W);

  // sequencer, one-hot
  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_M1   = 15'b000000000000010,  // first cross term, edge sums
    S_M2   = 15'b000000000000100,  // second cross term
    S_M3   = 15'b000000000001000,  // cross product
    S_M4   = 15'b000000000010000,  // x moment, cross sum
    S_M5   = 15'b000000000100000,  // y moment, x moment sum
    S_M6   = 15'b000000001000000,  // y moment sum
    S_FA   = 15'b000000010000000,  // |s|, sign, degenerate test
    S_FB   = 15'b000000100000000,  // 3|s|
    S_DA   = 15'b000001000000000,  // |m| and quotient sign
    S_DN   = 15'b000010000000000,  // dividend with rounding term
    S_DC   = 15'b000100000000000,  // overflow check, load remainder
    S_DI   = 15'b001000000000000,  // one quotient bit a cycle
    S_DD   = 15'b010000000000000,  // clamp and sign
    S_PUB  = 15'b100000000000000   // wait for the output register
  } state_t;

  state_t state, state_next;

  // control
  logic             in_polygon;
  logic             close_todo;
  logic             fin_todo;
  logic             sel_y;
  logic [CNT_W-1:0] cnt;

  // vertex and edge registers
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_BITS-1:0] e0x, e0y, e1x, e1y;
  logic signed [SUM_W-1:0]      sx, sy;
  logic signed [CP_W-1:0]       cp;
  logic signed [PROD_W-1:0]     prod;

  // accumulators
  logic [CROSS_W-1:0] cross_sum;
  logic [MOM_W-1:0]   moment_x_sum, moment_y_sum;

  // finishing and divider registers
  logic [CROSS_W-1:0] s_mag;
  logic               s_neg;
  logic               s_zero;
  logic [D1_W-1:0]    d3;
  logic [MOM_W-1:0]   m_mag;
  logic               q_neg;
  logic [NUM_W-1:0]   num;
  logic               ovf;
  logic [D_W-1:0]     rem;
  logic [CENT_W-1:0]  qsh;
  logic [CENT_W-1:0]  cx, cy;

  // shared multiplier
  logic signed [CP_W-1:0]   mul_a;
  logic signed [SUM_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // divider datapath
  logic [D_W-1:0]    dvs;
  logic [D_W:0]      trial;
  logic              take;
  logic [MOM_W-1:0]  m_sel;
  logic [CENT_W-1:0] lim;
  logic [CENT_W-1:0] q_mag;
  logic [CENT_W-1:0] q_res;

  logic vtx_acc;
  logic pub_go;

  assign vtx_acc      = vertex_valid && !vertex_stall;
  assign vertex_stall = (state != S_IDLE);
  assign pub_go       = (state == S_PUB) && (!result_valid || !result_stall);

  // operand selection for the one multiplier
  always_comb begin
    mul_a = cp;
    mul_b = sx;
    case (state)
      S_M1: begin
        mul_a = {{(CP_W - COORD_BITS){e0x[COORD_BITS-1]}}, e0x};
        mul_b = {{(SUM_W - COORD_BITS){e1y[COORD_BITS-1]}}, e1y};
      end
      S_M2: begin
        mul_a = {{(CP_W - COORD_BITS){e1x[COORD_BITS-1]}}, e1x};
        mul_b = {{(SUM_W - COORD_BITS){e0y[COORD_BITS-1]}}, e0y};
      end
      S_M5: begin
        mul_a = cp;
        mul_b = sy;
      end
      default: begin
        mul_a = cp;
        mul_b = sx;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divisor 6|s|, trial subtraction of one restoring step
  assign dvs   = {d3, 1'b0};
  assign trial = {rem, qsh[CENT_W-1]};
  assign take  = (trial >= {1'b0, dvs});
  assign m_sel = sel_y ? moment_y_sum : moment_x_sum;

  // saturation limit depends on the sign of the quotient
  assign lim   = q_neg ? {1'b1, {(CENT_W - 1){1'b0}}} : {1'b0, {(CENT_W - 1){1'b1}}};
  assign q_mag = (ovf || (qsh > lim)) ? lim : qsh;
  assign q_res = q_neg ? (~q_mag + 1'b1) : q_mag;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (vtx_acc) begin
          if (!in_polygon) begin
            // a lone vertex that is also the last one has no area
            state_next = last_vertex ? S_FA : S_IDLE;
          end else begin
            state_next = S_M1;
          end
        end
      end
      S_M1: state_next = S_M2;
      S_M2: state_next = S_M3;
      S_M3: state_next = S_M4;
      S_M4: state_next = S_M5;
      S_M5: state_next = S_M6;
      S_M6: begin
        if (close_todo) begin
          state_next = S_M1;
        end else if (fin_todo) begin
          state_next = S_FA;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FA: state_next = S_FB;
      S_FB: state_next = s_zero ? S_PUB : S_DA;
      S_DA: state_next = S_DN;
      S_DN: state_next = S_DC;
      S_DC: state_next = S_DI;
      S_DI: begin
        if (cnt == CNT_W'(CENT_W - 1)) begin
          state_next = S_DD;
        end
      end
      S_DD: state_next = sel_y ? S_PUB : S_DA;
      S_PUB: begin
        if (pub_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_polygon   <= 1'b0;
      close_todo   <= 1'b0;
      fin_todo     <= 1'b0;
      sel_y        <= 1'b0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (vtx_acc) begin
        in_polygon <= !(last_vertex && !in_polygon);
        close_todo <= last_vertex && in_polygon;
        fin_todo   <= last_vertex && in_polygon;
      end
      if (state == S_M6) begin
        close_todo <= 1'b0;
      end
      if (state == S_FA) begin
        in_polygon <= 1'b0;
        fin_todo   <= 1'b0;
        sel_y      <= 1'b0;
      end
      if (state == S_DC) begin
        cnt <= '0;
      end else if (state == S_DI) begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_DD) begin
        sel_y <= 1'b1;
      end
      if (pub_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (vtx_acc) begin
          prev_x <= vertex_x;
          prev_y <= vertex_y;
          e0x    <= prev_x;
          e0y    <= prev_y;
          e1x    <= vertex_x;
          e1y    <= vertex_y;
          if (!in_polygon) begin
            first_x      <= vertex_x;
            first_y      <= vertex_y;
            cross_sum    <= '0;
            moment_x_sum <= '0;
            moment_y_sum <= '0;
          end
        end
      end
      S_M1: begin
        prod <= mul_p;
        sx   <= SUM_W'(e0x) + SUM_W'(e1x);
        sy   <= SUM_W'(e0y) + SUM_W'(e1y);
      end
      S_M2: begin
        cp   <= prod[CP_W-1:0];
        prod <= mul_p;
      end
      S_M3: begin
        cp <= cp - prod[CP_W-1:0];
      end
      S_M4: begin
        prod      <= mul_p;
        cross_sum <= cross_sum + {{(CROSS_W - CP_W){cp[CP_W-1]}}, cp};
      end
      S_M5: begin
        prod         <= mul_p;
        moment_x_sum <= moment_x_sum + {{(MOM_W - PROD_W){prod[PROD_W-1]}}, prod};
      end
      S_M6: begin
        moment_y_sum <= moment_y_sum + {{(MOM_W - PROD_W){prod[PROD_W-1]}}, prod};
        // closing edge from the last vertex back to the first
        e0x <= prev_x;
        e0y <= prev_y;
        e1x <= first_x;
        e1y <= first_y;
      end
      S_FA: begin
        s_neg  <= cross_sum[CROSS_W-1];
        s_zero <= (cross_sum == '0);
        s_mag  <= cross_sum[CROSS_W-1] ? (~cross_sum + 1'b1) : cross_sum;
      end
      S_FB: begin
        d3 <= D1_W'(s_mag) + (D1_W'(s_mag) << 1);
      end
      S_DA: begin
        m_mag <= m_sel[MOM_W-1] ? (~m_sel + 1'b1) : m_sel;
        q_neg <= m_sel[MOM_W-1] ^ s_neg;
      end
      S_DN: begin
        // +3|s| over 6|s| rounds half away from zero on the magnitude
        num <= (NUM_W'(m_mag) << (FRAC_BITS + 1)) + NUM_W'(d3);
      end
      S_DC: begin
        ovf <= (CMP_W'(num[NUM_W-1:CENT_W]) >= CMP_W'(dvs));
        rem <= D_W'(num[NUM_W-1:CENT_W]);
        qsh <= num[CENT_W-1:0];
      end
      S_DI: begin
        rem <= take ? D_W'(trial - {1'b0, dvs}) : trial[D_W-1:0];
        qsh <= {qsh[CENT_W-2:0], take};
      end
      S_DD: begin
        if (sel_y) begin
          cy <= q_res;
        end else begin
          cx <= q_res;
        end
      end
      S_PUB: begin
        if (pub_go) begin
          degenerate <= s_zero;
          twice_area <= s_zero ? '0 : AREA_W'(s_mag);
          centroid_x <= s_zero ? '0 : cx;
          centroid_y <= s_zero ? '0 : cy;
        end
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for polygon_area_centroid
// streams vertex beats under random gaps and back-pressure, predicts each
// polygon's twice-area and Q.8 centroid, and checks every result beat in order
// ---------------------------------------------------------------------------
module tb;
  import pac_pkg::*;

  // stimulus and run limits
  localparam int LONG_POLY   = 160;        // long polygon on extreme coordinates
  localparam int HOLD_CYCLES = 400;        // receiver hold-off used to back the block up
  localparam int QUIET_LIMIT = 5000;       // cycles with no beat on either side
  localparam int TAIL_CYCLES = 100;        // settle margin after the last result beat
  localparam int IDLE_PCT    = 22;
  localparam int MAX_REPORTS = 50;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // how random coordinates of one polygon are drawn
  typedef enum int {NEAR_ORIGIN, FULL_SPAN, EDGE_VALUES} coord_span_t;

  typedef struct {
    logic        [AREA_W-1:0] area;
    logic signed [CENT_W-1:0] cx;
    logic signed [CENT_W-1:0] cy;
    logic                     degen;
  } polygon_result_t;

  // -------------------------------------------------------------------------
  // shoelace predictor and in-order store of expected polygon results
  // -------------------------------------------------------------------------
  class area_scoreboard;
    coord_t               first_x = '0, first_y = '0, prev_x = '0, prev_y = '0;
    bit                   poly_open = 1'b0;
    logic [CROSS_W-1:0]   cross_acc = '0;
    logic [MOM_W-1:0]     mom_x_acc = '0, mom_y_acc = '0;
    polygon_result_t      expected_q[$];
    int                   errors = 0;

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t mismatch: %s", $time, what);
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // cross product of one edge into the area sum and both moment sums
    function void add_edge(coord_t px, coord_t py, coord_t x, coord_t y);
      longint cp;
      cp = longint'(px) * longint'(y) - longint'(x) * longint'(py);
      cross_acc = cross_acc + CROSS_W'(cp);
      mom_x_acc = mom_x_acc + MOM_W'((longint'(px) + longint'(x)) * cp);
      mom_y_acc = mom_y_acc + MOM_W'((longint'(py) + longint'(y)) * cp);
    endfunction

    // moment / (3 * signed cross sum) in fixed point, half away from zero
    function logic [CENT_W-1:0] fixed_centroid(longint moment, longint csum);
      bit           neg;
      logic [63:0]  mag_m, mag_s;
      logic [127:0] num, den, quot, lim;
      neg   = (moment < 0) != (csum < 0);
      mag_m = (moment < 0) ? -moment : moment;
      mag_s = (csum < 0) ? -csum : csum;
      num   = ({64'd0, mag_m} << (FRAC_BITS_DEF + 1)) + {64'd0, mag_s} * 128'd3;
      den   = {64'd0, mag_s} * 128'd6;
      quot  = num / den;
      lim   = neg ? (128'd1 << (CENT_W - 1)) : (128'd1 << (CENT_W - 1)) - 128'd1;
      if (quot > lim)
        quot = lim;
      return neg ? CENT_W'(-quot) : CENT_W'(quot);
    endfunction

    function void note_vertex(coord_t x, coord_t y, logic last);
      longint          s;
      polygon_result_t r;
      if (!poly_open) begin
        first_x   = x;
        first_y   = y;
        cross_acc = '0;
        mom_x_acc = '0;
        mom_y_acc = '0;
        poly_open = 1'b1;
      end else begin
        add_edge(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      if (last) begin
        add_edge(prev_x, prev_y, first_x, first_y);
        s = longint'($signed(cross_acc));
        if (s == 0) begin
          r = '{area: '0, cx: '0, cy: '0, degen: 1'b1};
        end else begin
          r.area  = AREA_W'((s < 0) ? -s : s);
          r.cx    = fixed_centroid(longint'($signed(mom_x_acc)), s);
          r.cy    = fixed_centroid(longint'($signed(mom_y_acc)), s);
          r.degen = 1'b0;
        end
        expected_q.push_back(r);
        poly_open = 1'b0;
        cross_acc = '0;
        mom_x_acc = '0;
        mom_y_acc = '0;
      end
    endfunction

    task check_result(logic [AREA_W-1:0] area, logic signed [CENT_W-1:0] cx,
                      logic signed [CENT_W-1:0] cy, logic degen);
      polygon_result_t e;
      if (expected_q.size() == 0) begin
        report("result beat with no polygon outstanding");
      end else begin
        e = expected_q.pop_front();
        if (area !== e.area)
          report($sformatf("twice_area got %0d want %0d", area, e.area));
        if (cx !== e.cx)
          report($sformatf("centroid_x got %0d want %0d", cx, e.cx));
        if (cy !== e.cy)
          report($sformatf("centroid_y got %0d want %0d", cy, e.cy));
        if (degen !== e.degen)
          report($sformatf("degenerate got %0b want %0b", degen, e.degen));
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // clock, reset and the block
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  logic                     vertex_valid;
  logic                     vertex_stall;
  coord_t                   vertex_x;
  coord_t                   vertex_y;
  logic                     last_vertex;
  logic                     result_valid;
  logic                     result_stall;
  logic        [AREA_W-1:0] twice_area;
  logic signed [CENT_W-1:0] centroid_x;
  logic signed [CENT_W-1:0] centroid_y;
  logic                     degenerate;

  // gap and back-pressure controls shared by the sender and the receiver
  bit  idle_on  = 1'b1;
  bit  stall_on = 1'b1;
  bit  hold_req = 1'b0;    // toggled by the sender to ask for one hold-off
  int  items_sent = 0;
  int  quiet_cycles = 0;

  area_scoreboard sb = new();

  always #1 clk = ~clk;

  polygon_area_centroid u_top (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .last_vertex  (last_vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .twice_area   (twice_area),
    .centroid_x   (centroid_x),
    .centroid_y   (centroid_y),
    .degenerate   (degenerate)
  );

  // -------------------------------------------------------------------------
  // monitors: values read straight after the edge are the ones the edge saw
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && vertex_valid && !vertex_stall)
      sb.note_vertex(vertex_x, vertex_y, last_vertex);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(twice_area, centroid_x, centroid_y, degenerate);
  end

  // watchdog: a long spell with no beat moving on either side means a hang
  always @(posedge clk) begin
    if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // receiver: random stall, plus one long hold-off when asked for
  // -------------------------------------------------------------------------
  initial begin
    bit hold_seen;
    hold_seen = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        // the hold-off is timed here, so the sender keeps offering beats
        hold_seen    = hold_req;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= stall_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // -------------------------------------------------------------------------
  // sender
  // -------------------------------------------------------------------------
  // one vertex beat: optional gap first, then hold it until taken
  task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex_x     <= x;
    vertex_y     <= y;
    last_vertex  <= last;
    @(posedge clk);
    while (vertex_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic coord_t pick_coord(coord_span_t span);
    int v;
    case (span)
      NEAR_ORIGIN: begin
        v = int'($urandom_range(0, 512)) - 256;
        return COORD_BITS'(v);
      end
      FULL_SPAN: return COORD_BITS'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0:       return COORD_MIN;
          1:       return COORD_MIN + 16'sd1;
          2:       return -16'sd1;
          3:       return '0;
          4:       return COORD_MAX - 16'sd1;
          default: return COORD_MAX;
        endcase
      end
    endcase
  endfunction

  // mostly ordinary polygons, a few with one or two vertices, a few larger
  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return $urandom_range(1, 2);
    else if (r < 85)
      return $urandom_range(3, 8);
    else
      return $urandom_range(9, 24);
  endfunction

  task automatic send_polygon(input int n_vertices);
    coord_span_t span;
    span = coord_span_t'($urandom_range(0, 2));
    for (int i = 0; i < n_vertices; i++)
      send_vertex(pick_coord(span), pick_coord(span), i == n_vertices - 1);
  endtask

  task automatic send_random_until(input int target);
    while (items_sent < target)
      send_polygon(pick_size());
  endtask

  initial begin
    int base;
    rst          <= 1'b1;
    vertex_valid <= 1'b0;
    vertex_x     <= '0;
    vertex_y     <= '0;
    last_vertex  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: single-vertex polygon, straight after reset
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
    // two vertices across the full span: no area
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    // collinear triangle: degenerate
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd100, 16'sd100, 1'b0);
    send_vertex(16'sd200, 16'sd200, 1'b1);
    // the same triangle anticlockwise then clockwise: centroid must agree
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd256, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd256, 1'b1);
    send_vertex(16'sd0, 16'sd256, 1'b0);
    send_vertex(16'sd256, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd0, 1'b1);
    // square on the coordinate extremes: largest plain area
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    // lopsided bow-tie: lobes nearly cancel, so the centroid saturates
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MIN + 16'sd1, COORD_MAX, 1'b1);

    // random polygons with gaps and stalls on both sides
    send_random_until(200);

    // long receiver hold-off while vertices keep coming: block backs up
    hold_req <= ~hold_req;
    send_random_until(300);

    // sender pause until every polygon has been answered
    vertex_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // stretch with no gaps and no stalls at all
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_random_until(420);

    // long polygon on extreme coordinates: large sums of both signs
    idle_on  = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < LONG_POLY; i++)
      send_vertex(pick_coord(FULL_SPAN), pick_coord(EDGE_VALUES), i == LONG_POLY - 1);

    base = items_sent;
    send_random_until(base + 170);
    vertex_valid <= 1'b0;

    // drain, then give any stray result beat time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pac_pkg.sv
hdl/polygon_area_centroid.sv
tb/tb.sv
